FILE: rtl/pvt_pkg.sv
// shared constants, phase codes and result record for the valley/peak tracker
package pvt_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int INDEX_BITS  = 32;
	localparam int PHASE_BITS  = 2;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [PHASE_BITS-1:0] {
		PH_FIRST  = 2'd0,
		PH_PEAK   = 2'd1,
		PH_SECOND = 2'd2
	} phase_t;

	// first member lands in the highest bits
	typedef struct packed {
		logic [PHASE_BITS-1:0]         phase_before;
		logic [INDEX_BITS-1:0]         second_valley_index;
		logic signed [SAMPLE_BITS-1:0] second_valley_value;
		logic [INDEX_BITS-1:0]         peak_index;
		logic signed [SAMPLE_BITS-1:0] peak_value;
		logic [INDEX_BITS-1:0]         first_valley_index;
		logic signed [SAMPLE_BITS-1:0] first_valley_value;
		logic                          cycle_valid;
	} result_t;

	localparam int RESULT_BITS = $bits(result_t);
	localparam int OUT_BITS    = ((RESULT_BITS + 7) / 8) * 8;
	localparam int IN_BITS     = ((SAMPLE_BITS + 7) / 8) * 8;

endpackage

FILE: rtl/pvt_core.sv
// tracker state and per-sample update logic
module pvt_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic signed [pvt_pkg::SAMPLE_BITS-1:0] sample,
	output pvt_pkg::result_t                     res
);
	import pvt_pkg::*;

	phase_t                        phase_q, phase_n;
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic signed [SAMPLE_BITS-1:0] min_q, min_n;
	logic signed [SAMPLE_BITS-1:0] max_q, max_n;
	logic [INDEX_BITS-1:0]         count_q, count_n;
	logic [INDEX_BITS-1:0]         first_pos_q, first_pos_n;
	logic [INDEX_BITS-1:0]         peak_pos_q, peak_pos_n;
	logic [INDEX_BITS-1:0]         second_pos_q, second_pos_n;
	logic                          pos, neg, up, down;

	assign pos     = !sample[SAMPLE_BITS-1] && (sample != '0);
	assign neg     = sample[SAMPLE_BITS-1];
	assign up      = (prev_q[SAMPLE_BITS-1] || (prev_q == '0)) && pos;
	assign down    = !prev_q[SAMPLE_BITS-1] && neg;
	assign count_n = count_q + 1'b1;

	always_comb begin
		res              = '0;
		res.phase_before = phase_q;
		phase_n          = phase_q;
		min_n            = min_q;
		max_n            = max_q;
		first_pos_n      = first_pos_q;
		peak_pos_n       = peak_pos_q;
		second_pos_n     = second_pos_q;
		case (phase_q)
			PH_PEAK: begin
				if (pos && (sample > max_q)) begin
					max_n      = sample;
					peak_pos_n = count_n;
				end
				if (down) begin
					res.peak_value = max_n;
					res.peak_index = peak_pos_n;
					max_n          = SAMPLE_MIN;
					phase_n        = PH_SECOND;
				end
			end
			PH_SECOND: begin
				if (neg && (sample < min_q)) begin
					min_n        = sample;
					second_pos_n = count_n;
				end
				if (up) begin
					res.cycle_valid         = 1'b1;
					res.second_valley_value = min_n;
					res.second_valley_index = second_pos_n;
					res.first_valley_value  = min_n;
					res.first_valley_index  = second_pos_n;
					first_pos_n             = second_pos_n;
					min_n                   = SAMPLE_MAX;
					max_n                   = SAMPLE_MIN;
					phase_n                 = PH_PEAK;
				end
			end
			default: begin
				if (neg && (sample < min_q)) begin
					min_n       = sample;
					first_pos_n = count_n;
				end
				if (up) begin
					res.first_valley_value = min_n;
					res.first_valley_index = first_pos_n;
					min_n                  = SAMPLE_MAX;
					phase_n                = PH_PEAK;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FIRST;
			prev_q       <= '0;
			min_q        <= SAMPLE_MAX;
			max_q        <= SAMPLE_MIN;
			count_q      <= '0;
			first_pos_q  <= '0;
			peak_pos_q   <= '0;
			second_pos_q <= '0;
		end else if (en) begin
			phase_q      <= phase_n;
			prev_q       <= sample;
			min_q        <= min_n;
			max_q        <= max_n;
			count_q      <= count_n;
			first_pos_q  <= first_pos_n;
			peak_pos_q   <= peak_pos_n;
			second_pos_q <= second_pos_n;
		end
	end

`ifndef SYNTHESIS
	a_close_resets: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.cycle_valid |=> phase_q == PH_PEAK && min_q == SAMPLE_MAX
			&& max_q == SAMPLE_MIN)
		else $error("closing valley did not restart the peak search");
	a_close_carries: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.cycle_valid |=> first_pos_q == $past(res.second_valley_index))
		else $error("closing valley position not carried to first valley");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> count_q == INDEX_BITS'($past(count_q) + 1'b1))
		else $error("sample counter did not advance");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(phase_q) && $stable(count_q) && $stable(prev_q))
		else $error("tracker state moved without a sample");
`endif

endmodule

FILE: rtl/ppg_valley_peak_tracker_top.sv
// top level: input register, tracker core and result register on stream ports
// a sample taken into the input register passes through the core and shows on m_axis from the result register
// throughput: one sample per cycle while the result side does not stall, set by the compare and update in the core
// the input stage takes a new transfer while the result register waits, if the input stage is empty
// reset: arst_n clears phase, extremes, counter and positions, and empties both stages
module ppg_valley_peak_tracker_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [pvt_pkg::IN_BITS-1:0]  s_axis_tdata,  // sample
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// cycle_valid, first_valley_value, first_valley_index, peak_value,
	// peak_index, second_valley_value, second_valley_index, phase_before
	output logic [pvt_pkg::OUT_BITS-1:0] m_axis_tdata
);
	import pvt_pkg::*;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          m_tvalid_q;
	logic [OUT_BITS-1:0]           m_tdata_q;
	logic                          advance;
	result_t                       res;

	assign advance       = !m_tvalid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	pvt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance && valid_s1),
		.sample (sample_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				m_tvalid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1 <= s_axis_tdata[SAMPLE_BITS-1:0];
		end
		if (advance && valid_s1) begin
			m_tdata_q <= OUT_BITS'(res);
		end
	end

endmodule

FILE: tb/sv/ppg_valley_peak_tracker_top_test.sv
// testbench for the valley/peak tracker: stream stimulus, per-sample predictor and result check
module ppg_valley_peak_tracker_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	import pvt_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 150;
	localparam int REPORT_LIMIT = 60;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [IN_BITS-1:0]  s_axis_tdata;   // sample
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	// cycle_valid, first_valley_value, first_valley_index, peak_value,
	// peak_index, second_valley_value, second_valley_index, phase_before
	logic [OUT_BITS-1:0] m_axis_tdata;

	ppg_valley_peak_tracker_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// tracker state mirrored for prediction
	phase_t                        trk_phase;
	logic signed [SAMPLE_BITS-1:0] trk_prev;
	logic signed [SAMPLE_BITS-1:0] trk_min;
	logic signed [SAMPLE_BITS-1:0] trk_max;
	logic [INDEX_BITS-1:0]         trk_count;
	logic [INDEX_BITS-1:0]         trk_first_pos;
	logic [INDEX_BITS-1:0]         trk_peak_pos;
	logic [INDEX_BITS-1:0]         trk_second_pos;

	result_t pending_results[$];
	int      samples_sent;
	int      mismatches;
	int      quiet_cycles;
	int      hold_requests;
	int      hold_served;
	bit      tx_steady;
	bit      rx_steady;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic reset_tracker_state();
		trk_phase      = PH_FIRST;
		trk_prev       = '0;
		trk_min        = SAMPLE_MAX;
		trk_max        = SAMPLE_MIN;
		trk_count      = '0;
		trk_first_pos  = '0;
		trk_peak_pos   = '0;
		trk_second_pos = '0;
	endtask

	function automatic result_t next_tracker_result(input logic signed [SAMPLE_BITS-1:0] smp);
		result_t r;
		bit      rising;
		bit      falling;
		r              = '0;
		r.phase_before = trk_phase;
		rising         = (trk_prev <= 0) && (smp > 0);
		falling        = (trk_prev >= 0) && (smp < 0);
		trk_count      = trk_count + 1'b1;
		case (trk_phase)
			PH_PEAK: begin
				if (smp > 0 && smp > trk_max) begin
					trk_max      = smp;
					trk_peak_pos = trk_count;
				end
				if (falling) begin
					r.peak_value = trk_max;
					r.peak_index = trk_peak_pos;
					trk_max      = SAMPLE_MIN;
					trk_phase    = PH_SECOND;
				end
			end
			PH_SECOND: begin
				if (smp < 0 && smp < trk_min) begin
					trk_min        = smp;
					trk_second_pos = trk_count;
				end
				if (rising) begin
					r.cycle_valid         = 1'b1;
					r.second_valley_value = trk_min;
					r.second_valley_index = trk_second_pos;
					r.first_valley_value  = trk_min;
					r.first_valley_index  = trk_second_pos;
					trk_first_pos         = trk_second_pos;
					trk_min               = SAMPLE_MAX;
					trk_max               = SAMPLE_MIN;
					trk_phase             = PH_PEAK;
				end
			end
			default: begin
				if (smp < 0 && smp < trk_min) begin
					trk_min       = smp;
					trk_first_pos = trk_count;
				end
				if (rising) begin
					r.first_valley_value = trk_min;
					r.first_valley_index = trk_first_pos;
					trk_min              = SAMPLE_MAX;
					trk_phase            = PH_PEAK;
				end
			end
		endcase
		trk_prev = smp;
		return r;
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp);
		@(negedge clk);
		while (!tx_steady && $urandom_range(0, 99) < 14) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		pending_results.push_back(next_tracker_result(smp));
		samples_sent++;
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] level_of_sign(input bit negative,
			input int amp);
		int lvl;
		lvl = $urandom_range(1, (amp > 32767 && !negative) ? 32767 : amp);
		if (negative) lvl = -lvl;
		return SAMPLE_BITS'(lvl);
	endfunction

	// crossings with no qualifying sample before them report the untouched extremes
	task automatic test_sentinel_crossings();
		send_sample(16'sd5);
		send_sample(-16'sd7);
		send_sample(16'sd9);
	endtask

	// full-scale levels, ties, zero runs and crossings out of zero
	task automatic test_field_extremes();
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(16'sd0);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MIN);
		send_sample(-16'sd1);
		send_sample(16'sd0);
		send_sample(16'sd1);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(-16'sd32767);
		send_sample(16'sd0);
		send_sample(16'sd0);
		send_sample(SAMPLE_MAX);
		send_sample(16'sd0);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
	endtask

	// well-formed pulse cycles with random depth, height and length
	task automatic test_pulse_waveforms();
		int target;
		int amp;
		target = samples_sent + 730;
		while (samples_sent < target) begin
			tx_steady = (samples_sent > target - 500) && (samples_sent < target - 150);
			rx_steady = tx_steady;
			case ($urandom_range(0, 3))
				0:       amp = 32768;
				1:       amp = 4;
				default: amp = $urandom_range(5, 3000);
			endcase
			repeat ($urandom_range(1, 8)) send_sample(level_of_sign(1'b1, amp));
			if ($urandom_range(0, 3) == 0) send_sample('0);
			repeat ($urandom_range(1, 8)) send_sample(level_of_sign(1'b0, amp));
			if ($urandom_range(0, 3) == 0) send_sample('0);
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// result side holds off while samples keep coming, so the input must stall
	task automatic test_input_backpressure();
		tx_steady = 1'b1;
		hold_requests++;
		repeat (80) send_sample(level_of_sign(1'($urandom_range(0, 1)), $urandom_range(1, 32768)));
		tx_steady = 1'b0;
	endtask

	// random samples, long single-sign runs, zero runs and sign chatter
	task automatic test_noise_and_broken_cycles();
		int kind;
		repeat (120) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				send_sample(SAMPLE_BITS'($urandom_range(0, 65535)));
			end else if (kind == 6) begin
				repeat ($urandom_range(2, 6)) send_sample('0);
			end else if (kind == 7) begin
				repeat ($urandom_range(10, 30)) send_sample(level_of_sign(1'b1, 32768));
			end else if (kind == 8) begin
				repeat ($urandom_range(10, 30)) send_sample(level_of_sign(1'b0, 32768));
			end else begin
				repeat ($urandom_range(2, 8)) begin
					send_sample(16'sd1);
					send_sample(-16'sd1);
				end
			end
		end
	endtask

	// result side: random stalls, steady stretches and requested long hold-offs
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served++;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready <= rx_steady || ($urandom_range(0, 99) >= 14);
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t ns %s mismatch: expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[RESULT_BITS-1:0]);
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t ns unexpected result transfer: expected none actual %0h",
					$time, m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("cycle_valid", 64'(want.cycle_valid), 64'(got.cycle_valid));
				check_field("first_valley_value", 64'(want.first_valley_value),
					64'(got.first_valley_value));
				check_field("first_valley_index", 64'(want.first_valley_index),
					64'(got.first_valley_index));
				check_field("peak_value", 64'(want.peak_value), 64'(got.peak_value));
				check_field("peak_index", 64'(want.peak_index), 64'(got.peak_index));
				check_field("second_valley_value", 64'(want.second_valley_value),
					64'(got.second_valley_value));
				check_field("second_valley_index", 64'(want.second_valley_index),
					64'(got.second_valley_index));
				check_field("phase_before", 64'(want.phase_before), 64'(got.phase_before));
				check_field("tdata padding", 64'd0, 64'(m_axis_tdata[OUT_BITS-1:RESULT_BITS]));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		samples_sent  = 0;
		mismatches    = 0;
		quiet_cycles  = 0;
		hold_requests = 0;
		hold_served   = 0;
		tx_steady     = 1'b0;
		rx_steady     = 1'b0;
		reset_tracker_state();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_sentinel_crossings();
		test_field_extremes();
		test_pulse_waveforms();
		test_input_backpressure();
		test_noise_and_broken_cycles();

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
